@@ hdl/nearest_neighbor_upscaler_macros.svh @@
// assertion macros shared by the checker of the nearest-neighbor upscaler
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef NEAREST_NEIGHBOR_UPSCALER_MACROS_SVH
`define NEAREST_NEIGHBOR_UPSCALER_MACROS_SVH

// condition holds at every edge
`define NNU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define NNU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds at the edge after the antecedent
`define NNU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/nnu_pkg.sv @@
// shared types and constants of the nearest-neighbor upscaler
// used by the register file, controller, datapath and top level
package nnu_pkg;

  localparam int SRC_W       = 8;   // width of the source size registers
  localparam int TGT_W       = 11;  // width of the target size registers
  localparam int COORD_W     = 10;  // width of a row or column index
  localparam int PROD_W      = 18;  // coordinate times source size
  localparam int PIX_IO_W    = 32;  // pixel word on the ports
  localparam int S_TDATA_W   = 56;  // row, col, pixel packed, padded to bytes
  localparam int DIV_STEPS   = SRC_W;  // quotient is always below the source size
  localparam int REG_ADDR_W  = 4;

  typedef logic [SRC_W-1:0]   src_dim_t;
  typedef logic [TGT_W-1:0]   tgt_dim_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [PIX_IO_W-1:0] pix_t;
  typedef logic [1:0]         reg_idx_t;

  localparam reg_idx_t REG_SRC_H = 2'd0;
  localparam reg_idx_t REG_SRC_W = 2'd1;
  localparam reg_idx_t REG_TGT_H = 2'd2;
  localparam reg_idx_t REG_TGT_W = 2'd3;

  typedef struct packed {
    src_dim_t src_h;
    src_dim_t src_w;
    tgt_dim_t tgt_h;
    tgt_dim_t tgt_w;
  } cfg_t;

  typedef struct packed {
    logic capture;   // take the input item
    logic eval;      // range check, products, divider setup
    logic div_step;  // one restoring division step on both lanes
    logic mem_rd;    // read the plane store at the scaled address
    logic mem_wr;    // write the plane store (gated by range error)
    logic load_out;  // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic is_read;
    logic range_err;
  } dp_sts_t;

endpackage

@@ hdl/nearest_neighbor_upscaler.sv @@
// nearest-neighbor upscaler for one image plane
// input stream: s_axis_tuser selects load (0) or read (1); s_axis_tdata
//   carries row, column and the pixel word to store
// output stream: one result per input item; m_axis_tdata is the nearest
//   source pixel for a read (zero for a load), m_axis_tuser the range error
// apb port: source height, source width, target height, target width at
//   byte addresses 0, 4, 8, 12, write only while the block is idle
// sequence: an in-range read passes through capture, range check, the 8-step
//   serial divider that scales row and column in parallel, the store read
//   and the output load; a load skips the divider and writes the store, and
//   an out-of-range read skips the division steps and the store access
// one item is processed at a time; a new item is taken while the previous
//   result still sits in the output register, and if the receiver stalls the
//   block holds the finished result of the next item until that register frees
// reset clears the size registers to 1 and the control state; the plane
//   store is not cleared and must be loaded before it is read
// depends on nnu_pkg, nnu_regs, nnu_ctrl and nnu_datapath
module nearest_neighbor_upscaler #(
  parameter int MAX_SOURCE_HEIGHT = 128,
  parameter int MAX_SOURCE_WIDTH  = 128,
  parameter int MAX_TARGET_SIZE   = 1024,
  parameter int PIXEL_BITS        = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nnu_pkg::REG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [nnu_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // row_index, col_index, pixel_in, pad
  input  logic                            s_axis_tuser,  // req_type
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [nnu_pkg::PIX_IO_W-1:0]    m_axis_tdata,  // pixel_out
  output logic                            m_axis_tuser   // range_error
);

  nnu_pkg::cfg_t    cfg;
  nnu_pkg::dp_cmd_t cmd;
  nnu_pkg::dp_sts_t sts;

  nnu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nnu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  nnu_datapath #(
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_TARGET_SIZE   (MAX_TARGET_SIZE),
    .PIXEL_BITS        (PIXEL_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg),
    .in_is_read_i  (s_axis_tuser),
    .in_row_i      (s_axis_tdata[9:0]),
    .in_col_i      (s_axis_tdata[19:10]),
    .in_pix_i      (s_axis_tdata[51:20]),
    .pixel_out_o   (m_axis_tdata),
    .range_error_o (m_axis_tuser)
  );

endmodule

@@ hdl/nnu_regs.sv @@
// apb configuration registers of the nearest-neighbor upscaler
// depends on nnu_pkg for register indexes and the config struct
module nnu_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nnu_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output nnu_pkg::cfg_t                  cfg_o
);

  nnu_pkg::cfg_t   cfg_q, cfg_d;
  nnu_pkg::reg_idx_t idx;
  logic            wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        nnu_pkg::REG_SRC_H: cfg_d.src_h = pwdata[nnu_pkg::SRC_W-1:0];
        nnu_pkg::REG_SRC_W: cfg_d.src_w = pwdata[nnu_pkg::SRC_W-1:0];
        nnu_pkg::REG_TGT_H: cfg_d.tgt_h = pwdata[nnu_pkg::TGT_W-1:0];
        nnu_pkg::REG_TGT_W: cfg_d.tgt_w = pwdata[nnu_pkg::TGT_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nnu_pkg::REG_SRC_H: prdata = 32'(cfg_q.src_h);
      nnu_pkg::REG_SRC_W: prdata = 32'(cfg_q.src_w);
      nnu_pkg::REG_TGT_H: prdata = 32'(cfg_q.tgt_h);
      nnu_pkg::REG_TGT_W: prdata = 32'(cfg_q.tgt_w);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_h <= nnu_pkg::src_dim_t'(1);
      cfg_q.src_w <= nnu_pkg::src_dim_t'(1);
      cfg_q.tgt_h <= nnu_pkg::tgt_dim_t'(1);
      cfg_q.tgt_w <= nnu_pkg::tgt_dim_t'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/nnu_datapath.sv @@
// datapath of the nearest-neighbor upscaler: item registers, range check,
// two serial dividers, plane store memory and output payload; uses nnu_pkg
module nnu_datapath #(
  parameter int MAX_SOURCE_HEIGHT = 128,
  parameter int MAX_SOURCE_WIDTH  = 128,
  parameter int MAX_TARGET_SIZE   = 1024,
  parameter int PIXEL_BITS        = 32
) (
  input  logic              clk_i,
  input  nnu_pkg::dp_cmd_t  cmd_i,
  output nnu_pkg::dp_sts_t  sts_o,
  input  nnu_pkg::cfg_t     cfg_i,
  input  logic              in_is_read_i,
  input  nnu_pkg::coord_t   in_row_i,
  input  nnu_pkg::coord_t   in_col_i,
  input  nnu_pkg::pix_t     in_pix_i,
  output nnu_pkg::pix_t     pixel_out_o,
  output logic              range_error_o
);

  localparam int Depth = MAX_SOURCE_HEIGHT * MAX_SOURCE_WIDTH;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  // only the low 32 bits ever reach the port, so wider words add nothing
  localparam int WordW = (PIXEL_BITS < nnu_pkg::PIX_IO_W) ? PIXEL_BITS : nnu_pkg::PIX_IO_W;

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  logic              is_read_q;
  nnu_pkg::coord_t   row_q, col_q;
  nnu_pkg::pix_t     pix_q;
  logic              err_q, err_d;

  nnu_pkg::src_dim_t sh_eff, sw_eff;
  nnu_pkg::tgt_dim_t th_eff, tw_eff;

  // two restoring division lanes: row and column
  nnu_pkg::prod_t    rem_r_q, rem_r_d, dv_r_q, dv_r_d;
  nnu_pkg::prod_t    rem_c_q, rem_c_d, dv_c_q, dv_c_d;
  nnu_pkg::src_dim_t quo_r_q, quo_r_d, quo_c_q, quo_c_d;

  logic [AddrW-1:0]  waddr, raddr;
  nnu_pkg::pix_t     pixel_out_q;
  logic              range_err_q;

  // size registers clamped: zero acts as one, above the maximum acts as it
  always_comb begin
    if (cfg_i.src_h == '0) sh_eff = nnu_pkg::src_dim_t'(1);
    else if (int'(cfg_i.src_h) > MAX_SOURCE_HEIGHT)
      sh_eff = nnu_pkg::src_dim_t'(MAX_SOURCE_HEIGHT);
    else sh_eff = cfg_i.src_h;

    if (cfg_i.src_w == '0) sw_eff = nnu_pkg::src_dim_t'(1);
    else if (int'(cfg_i.src_w) > MAX_SOURCE_WIDTH)
      sw_eff = nnu_pkg::src_dim_t'(MAX_SOURCE_WIDTH);
    else sw_eff = cfg_i.src_w;

    if (cfg_i.tgt_h == '0) th_eff = nnu_pkg::tgt_dim_t'(1);
    else if (int'(cfg_i.tgt_h) > MAX_TARGET_SIZE)
      th_eff = nnu_pkg::tgt_dim_t'(MAX_TARGET_SIZE);
    else th_eff = cfg_i.tgt_h;

    if (cfg_i.tgt_w == '0) tw_eff = nnu_pkg::tgt_dim_t'(1);
    else if (int'(cfg_i.tgt_w) > MAX_TARGET_SIZE)
      tw_eff = nnu_pkg::tgt_dim_t'(MAX_TARGET_SIZE);
    else tw_eff = cfg_i.tgt_w;
  end

  always_comb begin
    if (is_read_q) begin
      err_d = (nnu_pkg::tgt_dim_t'(row_q) >= th_eff) ||
              (nnu_pkg::tgt_dim_t'(col_q) >= tw_eff);
    end else begin
      err_d = (row_q >= nnu_pkg::coord_t'(sh_eff)) ||
              (col_q >= nnu_pkg::coord_t'(sw_eff));
    end
  end

  always_comb begin
    rem_r_d = rem_r_q;
    dv_r_d  = dv_r_q;
    quo_r_d = quo_r_q;
    rem_c_d = rem_c_q;
    dv_c_d  = dv_c_q;
    quo_c_d = quo_c_q;
    if (cmd_i.eval) begin
      // dividend below divisor times 2^SRC_W, so SRC_W steps give the quotient
      rem_r_d = nnu_pkg::prod_t'(row_q) * nnu_pkg::prod_t'(sh_eff);
      rem_c_d = nnu_pkg::prod_t'(col_q) * nnu_pkg::prod_t'(sw_eff);
      dv_r_d  = nnu_pkg::prod_t'(th_eff) << (nnu_pkg::SRC_W - 1);
      dv_c_d  = nnu_pkg::prod_t'(tw_eff) << (nnu_pkg::SRC_W - 1);
      quo_r_d = '0;
      quo_c_d = '0;
    end else if (cmd_i.div_step) begin
      if (rem_r_q >= dv_r_q) begin
        rem_r_d = rem_r_q - dv_r_q;
        quo_r_d = {quo_r_q[nnu_pkg::SRC_W-2:0], 1'b1};
      end else begin
        quo_r_d = {quo_r_q[nnu_pkg::SRC_W-2:0], 1'b0};
      end
      if (rem_c_q >= dv_c_q) begin
        rem_c_d = rem_c_q - dv_c_q;
        quo_c_d = {quo_c_q[nnu_pkg::SRC_W-2:0], 1'b1};
      end else begin
        quo_c_d = {quo_c_q[nnu_pkg::SRC_W-2:0], 1'b0};
      end
      dv_r_d = dv_r_q >> 1;
      dv_c_d = dv_c_q >> 1;
    end
  end

  assign waddr = AddrW'(row_q) * AddrW'(MAX_SOURCE_WIDTH) + AddrW'(col_q);
  assign raddr = AddrW'(quo_r_q) * AddrW'(MAX_SOURCE_WIDTH) + AddrW'(quo_c_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && !err_q) begin
      mem[waddr] <= pix_q[WordW-1:0];
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_read_q <= in_is_read_i;
      row_q     <= in_row_i;
      col_q     <= in_col_i;
      pix_q     <= in_pix_i;
    end
    if (cmd_i.eval) begin
      err_q <= err_d;
    end
    rem_r_q <= rem_r_d;
    dv_r_q  <= dv_r_d;
    quo_r_q <= quo_r_d;
    rem_c_q <= rem_c_d;
    dv_c_q  <= dv_c_d;
    quo_c_q <= quo_c_d;
    if (cmd_i.load_out) begin
      pixel_out_q <= (is_read_q && !err_q) ? nnu_pkg::pix_t'(rdata_q) : '0;
      range_err_q <= err_q;
    end
  end

  assign sts_o.is_read   = is_read_q;
  assign sts_o.range_err = err_q;
  assign pixel_out_o     = pixel_out_q;
  assign range_error_o   = range_err_q;

endmodule

@@ hdl/nnu_ctrl.sv @@
// controller of the nearest-neighbor upscaler: sequences capture, check,
// division, store access and output transfer; uses nnu_pkg command types
module nnu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nnu_pkg::dp_cmd_t cmd_o,
  input  nnu_pkg::dp_sts_t sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int CntW = (nnu_pkg::DIV_STEPS > 1) ? $clog2(nnu_pkg::DIV_STEPS) : 1;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        cnt_d      = '0;
        state_d    = sts_i.is_read ? S_DIV : S_WRITE;
      end
      S_DIV: begin
        // out-of-range reads skip the divider
        if (sts_i.range_err) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == CntW'(nnu_pkg::DIV_STEPS - 1)) begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/nnu_checker.sv @@
// port-level checker for the nearest-neighbor upscaler, bound to the top level
// depends on nearest_neighbor_upscaler_macros.svh and nnu_pkg
`include "nearest_neighbor_upscaler_macros.svh"

module nnu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [nnu_pkg::PIX_IO_W-1:0] m_axis_tdata,
  input logic                         m_axis_tuser
);

  // a stalled result keeps its payload
  `NNU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // one item at a time: busy right after an input transfer
  `NNU_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

  // a flagged item never returns pixel data
  `NNU_ASSERT_IMPLIES(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "range error with nonzero pixel")

  // a new result is only produced while an item is in progress
  `NNU_ASSERT_IMPLIES(a_out_from_item, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without an item")

endmodule

bind nearest_neighbor_upscaler nnu_checker u_checker (.*);

@@ sim/nearest_neighbor_upscaler_tb.sv @@
// testbench of the nearest-neighbor upscaler: sets the plane sizes over apb, streams loads
// and reads, and checks every result against a scoreboard that mirrors the plane store
// depends on nnu_pkg and nearest_neighbor_upscaler
module nearest_neighbor_upscaler_tb;

  localparam int SRC_MAX     = 128;
  localparam int TGT_MAX     = 1024;
  localparam int COORD_MAX   = 1023;
  localparam int STORE_DEPTH = SRC_MAX * SRC_MAX;
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [nnu_pkg::REG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [nnu_pkg::S_TDATA_W-1:0]  s_axis_tdata;  // row_index, col_index, pixel_in, pad
  logic                           s_axis_tuser;  // req_type
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [nnu_pkg::PIX_IO_W-1:0]   m_axis_tdata;  // pixel_out
  logic                           m_axis_tuser;  // range_error

  typedef struct {
    nnu_pkg::pix_t pixel;
    logic          range_err;
  } upscale_result_t;

  class upscale_scoreboard;
    nnu_pkg::src_dim_t src_h;
    nnu_pkg::src_dim_t src_w;
    nnu_pkg::tgt_dim_t tgt_h;
    nnu_pkg::tgt_dim_t tgt_w;
    nnu_pkg::pix_t     plane [STORE_DEPTH];
    bit                loaded [STORE_DEPTH];
    upscale_result_t   expected_q [$];
    int                failures;

    function new();
      src_h    = 1;
      src_w    = 1;
      tgt_h    = 1;
      tgt_w    = 1;
      failures = 0;
    endfunction

    function void write_register(nnu_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        nnu_pkg::REG_SRC_H: src_h = value[nnu_pkg::SRC_W-1:0];
        nnu_pkg::REG_SRC_W: src_w = value[nnu_pkg::SRC_W-1:0];
        nnu_pkg::REG_TGT_H: tgt_h = value[nnu_pkg::TGT_W-1:0];
        nnu_pkg::REG_TGT_W: tgt_w = value[nnu_pkg::TGT_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything above the maximum as the maximum
    function int clamp_dim(int v, int max);
      if (v == 0) return 1;
      return (v > max) ? max : v;
    endfunction

    function void get_dims(output int sh, output int sw, output int th, output int tw);
      sh = clamp_dim(int'(src_h), SRC_MAX);
      sw = clamp_dim(int'(src_w), SRC_MAX);
      th = clamp_dim(int'(tgt_h), TGT_MAX);
      tw = clamp_dim(int'(tgt_w), TGT_MAX);
    endfunction

    // store address of the source pixel that an in-range read maps to
    function int scaled_addr(nnu_pkg::coord_t row, nnu_pkg::coord_t col);
      int sh, sw, th, tw;
      get_dims(sh, sw, th, tw);
      return ((int'(row) * sh) / th) * SRC_MAX + (int'(col) * sw) / tw;
    endfunction

    function void note_request(logic kind, nnu_pkg::coord_t row, nnu_pkg::coord_t col,
                               nnu_pkg::pix_t pix);
      int sh, sw, th, tw, addr;
      upscale_result_t res;
      get_dims(sh, sw, th, tw);
      res.pixel     = '0;
      res.range_err = 1'b0;
      if (kind == REQ_LOAD) begin
        if (int'(row) >= sh || int'(col) >= sw) begin
          res.range_err = 1'b1;
        end else begin
          addr         = int'(row) * SRC_MAX + int'(col);
          plane[addr]  = pix;
          loaded[addr] = 1'b1;
        end
      end else begin
        if (int'(row) >= th || int'(col) >= tw) begin
          res.range_err = 1'b1;
        end else begin
          res.pixel = plane[scaled_addr(row, col)];
        end
      end
      expected_q.push_back(res);
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_response(nnu_pkg::pix_t pix, logic err);
      upscale_result_t exp_res;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result pixel %h range_err %b", pix, err));
        return;
      end
      exp_res = expected_q.pop_front();
      if (pix !== exp_res.pixel || err !== exp_res.range_err)
        flag($sformatf("pixel exp %h got %h, range_err exp %b got %b",
                       exp_res.pixel, pix, exp_res.range_err, err));
    endfunction
  endclass

  upscale_scoreboard sb;
  int                send_calm;

  nearest_neighbor_upscaler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random wait before an item, with occasional stretches of back-to-back transfers
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  task automatic apb_write(input nnu_pkg::reg_idx_t idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // tvalid stays high across back-to-back items, lowered only for a gap
  task automatic send_request(input logic kind, input nnu_pkg::coord_t row,
                              input nnu_pkg::coord_t col, input nnu_pkg::pix_t pix);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, pix, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, row, col, pix);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // reads only source pixels that were loaded, loading the missing one first
  task automatic read_in_range();
    int sh, sw, th, tw, addr;
    nnu_pkg::coord_t row, col;
    sb.get_dims(sh, sw, th, tw);
    row  = nnu_pkg::coord_t'($urandom_range(0, th - 1));
    col  = nnu_pkg::coord_t'($urandom_range(0, tw - 1));
    addr = sb.scaled_addr(row, col);
    if (!sb.loaded[addr])
      send_request(REQ_LOAD, nnu_pkg::coord_t'(addr / SRC_MAX),
                   nnu_pkg::coord_t'(addr % SRC_MAX), $urandom());
    send_request(REQ_READ, row, col, $urandom());
  endtask

  task automatic run_phase(input int sh_reg, input int sw_reg, input int th_reg,
                           input int tw_reg, input int count);
    int sh, sw, th, tw, pick;
    nnu_pkg::coord_t row, col;
    wait_idle();
    apb_write(nnu_pkg::REG_SRC_H, sh_reg);
    apb_write(nnu_pkg::REG_SRC_W, sw_reg);
    apb_write(nnu_pkg::REG_TGT_H, th_reg);
    apb_write(nnu_pkg::REG_TGT_W, tw_reg);
    sb.get_dims(sh, sw, th, tw);
    // small planes get a full load up front
    if (sh * sw <= 64) begin
      for (int r = 0; r < sh; r++)
        for (int c = 0; c < sw; c++)
          send_request(REQ_LOAD, nnu_pkg::coord_t'(r), nnu_pkg::coord_t'(c), $urandom());
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_request(REQ_LOAD, nnu_pkg::coord_t'($urandom_range(0, sh - 1)),
                     nnu_pkg::coord_t'($urandom_range(0, sw - 1)), $urandom());
      end else if (pick < 33) begin
        row = nnu_pkg::coord_t'($urandom_range(0, COORD_MAX));
        col = nnu_pkg::coord_t'($urandom_range(0, COORD_MAX));
        if ($urandom_range(0, 1)) row = nnu_pkg::coord_t'($urandom_range(sh, COORD_MAX));
        else col = nnu_pkg::coord_t'($urandom_range(sw, COORD_MAX));
        send_request(REQ_LOAD, row, col, $urandom());
      end else if (pick < 90 || (th == TGT_MAX && tw == TGT_MAX)) begin
        read_in_range();
      end else begin
        row = nnu_pkg::coord_t'($urandom_range(0, COORD_MAX));
        col = nnu_pkg::coord_t'($urandom_range(0, COORD_MAX));
        if (th < TGT_MAX && (tw == TGT_MAX || $urandom_range(0, 1)))
          row = nnu_pkg::coord_t'($urandom_range(th, COORD_MAX));
        else
          col = nnu_pkg::coord_t'($urandom_range(tw, COORD_MAX));
        send_request(REQ_READ, row, col, $urandom());
      end
    end
  endtask

  initial begin
    sb            = new();
    send_calm     = 0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_LOAD;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // one by one plane after reset, out-of-range loads and reads
    send_request(REQ_LOAD, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd0, 10'd0, 32'h0000_0000);
    send_request(REQ_LOAD, 10'd1, 10'd0, 32'h1234_5678);
    send_request(REQ_LOAD, 10'd0, 10'd1023, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd1, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd0, 10'd1, 32'h0000_0000);
    send_request(REQ_READ, 10'd1023, 10'd1023, 32'h0000_0000);
    send_request(REQ_LOAD, 10'd0, 10'd0, 32'h0000_0000);
    send_request(REQ_READ, 10'd0, 10'd0, 32'hFFFF_FFFF);

    // largest source and target, corners of both planes
    wait_idle();
    apb_write(nnu_pkg::REG_SRC_H, SRC_MAX);
    apb_write(nnu_pkg::REG_SRC_W, SRC_MAX);
    apb_write(nnu_pkg::REG_TGT_H, TGT_MAX);
    apb_write(nnu_pkg::REG_TGT_W, TGT_MAX);
    send_request(REQ_LOAD, 10'd127, 10'd127, 32'hA5A5_A5A5);
    send_request(REQ_LOAD, 10'd0, 10'd0, 32'h5A5A_5A5A);
    send_request(REQ_LOAD, 10'd127, 10'd0, 32'hDEAD_BEEF);
    send_request(REQ_LOAD, 10'd0, 10'd127, 32'h0F0F_F0F0);
    send_request(REQ_LOAD, 10'd128, 10'd5, 32'hFFFF_FFFF);
    send_request(REQ_LOAD, 10'd5, 10'd1023, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd1023, 10'd1023, 32'h0000_0000);
    send_request(REQ_READ, 10'd0, 10'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ, 10'd1023, 10'd0, 32'h0000_0000);
    send_request(REQ_READ, 10'd0, 10'd1023, 32'hFFFF_FFFF);

    // zero sizes act as one, oversized ones as the maximum; then fixed and random sizes
    run_phase(0, 0, 0, 0, 60);
    run_phase(255, 255, 2047, 2047, 150);
    run_phase(4, 4, 8, 8, 120);
    run_phase(3, 5, 7, 1000, 120);
    run_phase(128, 128, 1, 1, 60);
    run_phase(1, 1, 1024, 1024, 100);
    run_phase(16, 16, 1024, 768, 150);
    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 3) == 0)
        run_phase($urandom_range(1, 128), $urandom_range(1, 128),
                  $urandom_range(1, 1024), $urandom_range(1, 1024), 90);
      else
        run_phase($urandom_range(1, 16), $urandom_range(1, 16),
                  $urandom_range(1, 64), $urandom_range(1, 64), 90);
    end

    wait_idle();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side; one long hold-off lets the block fill up and stall its input
  initial begin : response_side
    int gap;
    int taken;
    int calm;
    taken = 0;
    calm  = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = (taken == 250) ? 600 : draw_gap(calm);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_response(m_axis_tdata, m_axis_tuser);
      taken++;
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
